// ===== rtl/sha1_pkg.sv =====
package sha1_pkg;

    localparam int DIGEST_WORDS = 5;
    localparam int ROUNDS       = 80;
    localparam int BLOCK_WORDS  = 16;
    localparam int LEN_OFFSET   = 56;

    localparam logic [31:0] INIT_H [0:DIGEST_WORDS-1] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_00_19 = 32'h5A827999;
    localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
    localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
    localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_LENHI,
        ST_LENLO,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/sha1_hash_engine.sv =====
// Input: one word per cycle while idle; a block that completes is compressed by the round unit
// and then added into the chaining value before another word is accepted.
// Last word: padding (0x80, realign, zero fill by words, offset check), the two length
// words, one or two compressions, each followed by the chain add, then 5 digest transfers.
// Throughput is set by the single shared round unit, one SHA-1 round per cycle.
// Synchronous active-low reset loads the initial chaining value and clears counters.
module sha1_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] data_word
    input  logic [2:0]  s_axis_tuser,   // [2:0] byte_count
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast
);
    import sha1_pkg::*;

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    logic [31:0] r_chain [0:DIGEST_WORDS-1];
    logic [31:0] r_w [0:BLOCK_WORDS-1];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_part;
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [6:0]  r_round;
    logic [2:0]  r_oidx;

    logic        push_en;
    logic [31:0] push_word;
    logic [2:0]  push_cnt;
    logic [2:0]  in_cnt;
    logic [1:0]  pb;
    logic [31:0] mask;
    logic [63:0] combined;
    logic [2:0]  total;
    logic [6:0]  fill_sum;
    logic        fill_full;
    logic        word_done;
    logic        start_comp;
    logic        out_xfer;

    logic [31:0] f_val, k_val, tmp, w_new;

    assign in_cnt        = (s_axis_tuser > 3'd4) ? 3'd4 : s_axis_tuser;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = r_chain[r_oidx];
    assign m_axis_tuser  = r_oidx;
    assign m_axis_tlast  = (r_oidx == 3'(DIGEST_WORDS - 1));
    assign out_xfer      = m_axis_tvalid && m_axis_tready;

    // byte merger: append push_cnt left-aligned bytes behind the pending partial bytes
    always_comb begin
        pb = r_fill[1:0];
        case (push_cnt)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'hFF00_0000;
            3'd2:    mask = 32'hFFFF_0000;
            3'd3:    mask = 32'hFFFF_FF00;
            default: mask = 32'hFFFF_FFFF;
        endcase
        combined  = {r_part, 32'h0} | ({push_word & mask, 32'h0} >> {pb, 3'b000});
        total     = {1'b0, pb} + push_cnt;
        fill_sum  = {1'b0, r_fill} + {4'b0, push_cnt};
        fill_full = fill_sum[6];
        word_done = total[2];
    end

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        push_en   = 1'b0;
        push_word = 32'h0;
        push_cnt  = 3'd0;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    push_en   = 1'b1;
                    push_word = s_axis_tdata;
                    push_cnt  = in_cnt;
                    if (fill_full) begin
                        n_state = ST_ROUND;
                        n_ret   = s_axis_tlast ? ST_PAD80 : ST_IDLE;
                    end else if (s_axis_tlast) begin
                        n_state = ST_PAD80;
                    end
                end
            end
            ST_PAD80: begin
                push_en   = 1'b1;
                push_word = {PAD_BYTE, 24'h0};
                push_cnt  = 3'd1;
                n_ret     = ST_PADZ;
                n_state   = fill_full ? ST_ROUND : ST_PADZ;
            end
            ST_PADZ: begin
                if (r_fill == 6'(LEN_OFFSET)) begin
                    n_state = ST_LENHI;
                end else begin
                    // realign to a word boundary first, then fill by whole words
                    push_en  = 1'b1;
                    push_cnt = (pb == 2'd0) ? 3'd4 : (3'd4 - {1'b0, pb});
                    n_ret    = ST_PADZ;
                    if (fill_full) begin
                        n_state = ST_ROUND;
                    end
                end
            end
            ST_LENHI: begin
                push_en   = 1'b1;
                push_word = r_bits[63:32];
                push_cnt  = 3'd4;
                n_state   = ST_LENLO;
            end
            ST_LENLO: begin
                push_en   = 1'b1;
                push_word = r_bits[31:0];
                push_cnt  = 3'd4;
                n_ret     = ST_OUT;
                n_state   = ST_ROUND;
            end
            ST_ROUND: begin
                if (r_round == 7'(ROUNDS - 1)) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_state = r_ret;
            end
            ST_OUT: begin
                if (out_xfer && m_axis_tlast) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign start_comp = push_en && fill_full;

    // shared round unit
    always_comb begin
        if (r_round < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = K_00_19;
        end else if (r_round < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_20_39;
        end else if (r_round < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = K_40_59;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_60_79;
        end
        tmp   = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + r_w[0];
        w_new = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_new = {w_new[30:0], w_new[31]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                r_chain[i] <= INIT_H[i];
            end
            r_part  <= 32'h0;
            r_fill  <= 6'd0;
            r_bits  <= 64'h0;
            r_round <= 7'd0;
            r_oidx  <= 3'd0;
        end else begin
            if (push_en) begin
                r_part <= word_done ? combined[31:0] : combined[63:32];
                r_fill <= fill_sum[5:0];
            end
            if ((r_state == ST_IDLE) && s_axis_tvalid) begin
                r_bits <= r_bits + {58'h0, in_cnt, 3'b000};
            end
            if (start_comp) begin
                r_round <= 7'd0;
            end else if (r_state == ST_ROUND) begin
                r_round <= r_round + 7'd1;
            end
            if (r_state == ST_ADD) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
                r_chain[4] <= r_chain[4] + r_e;
            end
            if (out_xfer) begin
                if (m_axis_tlast) begin
                    // start the next message from scratch
                    r_oidx <= 3'd0;
                    for (int i = 0; i < DIGEST_WORDS; i++) begin
                        r_chain[i] <= INIT_H[i];
                    end
                    r_part <= 32'h0;
                    r_fill <= 6'd0;
                    r_bits <= 64'h0;
                end else begin
                    r_oidx <= r_oidx + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en && word_done) begin
            r_w[r_fill[5:2]] <= combined[63:32];
        end else if (r_state == ST_ROUND) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[BLOCK_WORDS-1] <= w_new;
        end
        if (start_comp) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end else if (r_state == ST_ROUND) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= tmp;
        end
    end

`ifndef SYNTHESIS
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_round < 7'(ROUNDS)))
        else $error("round counter out of range");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted while digest is presented");

    a_add_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD) |=> (r_state == $past(r_ret)))
        else $error("sequencer did not return after chain add");

    a_len_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LENHI) |-> (r_fill == 6'(LEN_OFFSET)))
        else $error("length field not at block offset 56");

    a_out_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_oidx < 3'(DIGEST_WORDS)))
        else $error("digest index out of range");
`endif

endmodule
